### rtl/sle_pkg.sv
// Shared types and constants for the sorted list engine.
// No dependencies; used by every module of the block.
`default_nettype none

package sle_pkg;

    // Number of list cells and the widths that follow from it
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Stream payload widths
    localparam int IN_W   = 40;
    localparam int OUT_W  = 48;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BADPOS = 3'd2,
        ST_FULL   = 3'd3,
        ST_NOKEY  = 3'd4
    } t_status;

    // Broadcast to every cell in the row
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
        logic [CNT_W-1:0]        count;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### rtl/sle_cell.sv
// One cell of the sorted list: holds one entry and moves it with its neighbours.
// Depends on sle_pkg.
`default_nettype none

module sle_cell (
    input  wire logic                            i_clk,
    input  wire logic [sle_pkg::IDX_W-1:0]       i_index,
    input  wire sle_pkg::t_cell_ctrl             i_ctrl,
    input  wire logic signed [sle_pkg::VAL_W-1:0] i_left_entry,
    input  wire logic                            i_left_le,
    input  wire logic signed [sle_pkg::VAL_W-1:0] i_right_entry,
    output logic signed [sle_pkg::VAL_W-1:0]     o_entry,
    output logic                                 o_le,
    output logic                                 o_hit,
    output logic signed [sle_pkg::VAL_W-1:0]     o_pick
);

    logic signed [sle_pkg::VAL_W-1:0] r_entry;
    logic signed [sle_pkg::VAL_W-1:0] n_entry;
    logic [sle_pkg::CMP_W-1:0]        w_idx;
    logic [sle_pkg::CMP_W-1:0]        w_pos;
    logic                             w_valid;
    logic                             w_at_or_after;

    assign w_idx   = sle_pkg::CMP_W'(i_index);
    assign w_pos   = sle_pkg::CMP_W'(i_ctrl.pos);
    assign w_valid = w_idx < sle_pkg::CMP_W'(i_ctrl.count);

    // Entry is at or before the insertion point
    assign o_le  = w_valid && (r_entry <= i_ctrl.value);
    assign o_hit = w_valid && (r_entry == i_ctrl.value);

    // Cell named by the 1-based delete position
    assign w_at_or_after = (w_idx + sle_pkg::CMP_W'(1)) >= w_pos;
    assign o_pick = ((w_idx + sle_pkg::CMP_W'(1)) == w_pos) ? r_entry : '0;

    assign o_entry = r_entry;

    // Keep, load the new value, or shift from a neighbour
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins && !o_le) begin
            if (i_left_le) begin
                n_entry = i_ctrl.value;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctrl.del && w_at_or_after) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

### rtl/sorted_list_engine_core.sv
// Top level of the sorted list engine: a row of sle_cell and the result register.
// Depends on sle_pkg and sle_cell.
`default_nettype none

// Keeps up to DEPTH (16) signed 32-bit values in ascending order in a row of
// cells, one entry per cell. Every command (insert in order, delete at a
// 1-based position, search for a key) is worked in parallel: all cells
// compare against the broadcast value at once and each loads its new entry
// from itself, the command or a neighbour. One result per command leaves
// through a registered output stage, and a new command is taken every cycle
// while that stage is empty or being drained, so the rate is one command per
// clock. No clearing pass is needed; reset clears only the count and output valid.

module sorted_list_engine_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command [1:0], value [33:2], position [38:34]
    input  wire logic [sle_pkg::IN_W-1:0]    i_s_tdata,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // status [2:0], found [3], removed_value [35:4], count [40:36]
    output logic [sle_pkg::OUT_W-1:0]        o_m_tdata,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready
);

    logic [1:0]                       w_cmd;
    logic signed [sle_pkg::VAL_W-1:0] w_value;
    logic [sle_pkg::POS_W-1:0]        w_pos;
    logic                             w_accept;
    logic                             w_full;
    logic                             w_empty;
    logic                             w_pos_ok;
    sle_pkg::t_cell_ctrl              w_ctrl;

    logic signed [sle_pkg::VAL_W-1:0] w_entry [sle_pkg::DEPTH];
    logic [sle_pkg::DEPTH-1:0]        w_le;
    logic [sle_pkg::DEPTH-1:0]        w_hit;
    logic signed [sle_pkg::VAL_W-1:0] w_pick  [sle_pkg::DEPTH];
    logic signed [sle_pkg::VAL_W-1:0] w_removed;

    logic [sle_pkg::CNT_W-1:0]        r_count;
    logic [sle_pkg::CNT_W-1:0]        n_count;
    logic                             r_out_valid;
    logic [sle_pkg::OUT_W-1:0]        r_out_data;
    logic [sle_pkg::OUT_W-1:0]        n_out_data;
    sle_pkg::t_status                 w_status;
    logic                             w_found;
    logic signed [sle_pkg::VAL_W-1:0] w_rm_out;

    // Unpack the command transfer
    assign w_cmd   = i_s_tdata[1:0];
    assign w_value = i_s_tdata[33:2];
    assign w_pos   = i_s_tdata[38:34];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_full   = r_count >= sle_pkg::CNT_W'(sle_pkg::DEPTH);
    assign w_empty  = r_count == '0;
    assign w_pos_ok = (w_pos != '0) &&
                      (sle_pkg::CMP_W'(w_pos) <= sle_pkg::CMP_W'(r_count));

    // Broadcast to the row
    always_comb begin
        w_ctrl.ins   = w_accept && (w_cmd == sle_pkg::CMD_INSERT) && !w_full;
        w_ctrl.del   = w_accept && (w_cmd == sle_pkg::CMD_DELETE) && !w_empty && w_pos_ok;
        w_ctrl.value = w_value;
        w_ctrl.pos   = w_pos;
        w_ctrl.count = r_count;
    end

    // Row of cells
    for (genvar g = 0; g < sle_pkg::DEPTH; g++) begin : g_cell
        logic signed [sle_pkg::VAL_W-1:0] w_left;
        logic                             w_left_le;
        logic signed [sle_pkg::VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_le = 1'b1;
        end else begin : g_inner
            assign w_left    = w_entry[g-1];
            assign w_left_le = w_le[g-1];
        end

        if (g == sle_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        sle_cell u_cell (
            .i_clk         (i_clk),
            .i_index       (sle_pkg::IDX_W'(g)),
            .i_ctrl        (w_ctrl),
            .i_left_entry  (w_left),
            .i_left_le     (w_left_le),
            .i_right_entry (w_right),
            .o_entry       (w_entry[g]),
            .o_le          (w_le[g]),
            .o_hit         (w_hit[g]),
            .o_pick        (w_pick[g])
        );
    end

    // Gather the entry at the delete position
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < sle_pkg::DEPTH; k++) begin
            w_removed = w_removed | w_pick[k];
        end
    end

    // Build the result and the next count
    always_comb begin
        w_status = sle_pkg::ST_DONE;
        w_found  = 1'b0;
        w_rm_out = '0;
        n_count  = r_count;
        case (w_cmd)
            sle_pkg::CMD_INSERT: begin
                if (w_full) begin
                    w_status = sle_pkg::ST_FULL;
                end else begin
                    n_count = r_count + sle_pkg::CNT_W'(1);
                end
            end
            sle_pkg::CMD_DELETE: begin
                if (w_empty) begin
                    w_status = sle_pkg::ST_EMPTY;
                end else if (!w_pos_ok) begin
                    w_status = sle_pkg::ST_BADPOS;
                end else begin
                    w_rm_out = w_removed;
                    n_count  = r_count - sle_pkg::CNT_W'(1);
                end
            end
            sle_pkg::CMD_SEARCH: begin
                if (w_empty) begin
                    w_status = sle_pkg::ST_EMPTY;
                end else if (|w_hit) begin
                    w_found = 1'b1;
                end else begin
                    w_status = sle_pkg::ST_NOKEY;
                end
            end
            default: begin
                w_status = sle_pkg::ST_DONE;
            end
        endcase
        n_out_data = {7'd0, n_count, w_rm_out, w_found, w_status};
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until transferred
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

### rtl/sle_checker.sv
// Port-level checks for the sorted list engine, bound to the top level.
// Depends on sle_pkg and sorted_list_engine_core.
`default_nettype none

module sle_checker (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [sle_pkg::IN_W-1:0] i_s_tdata,
    input  wire logic                     i_s_tvalid,
    input  wire logic                     o_s_tready,
    input  wire logic [sle_pkg::OUT_W-1:0] o_m_tdata,
    input  wire logic                     o_m_tvalid,
    input  wire logic                     i_m_tready
);

    // A pending result stays offered until transferred
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped before transfer");

    // Every accepted command yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("no result after command");

    // Count never exceeds the capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[40:36] <= 5'(sle_pkg::DEPTH)))
        else $error("count above capacity");

    // A match is only reported with a clean status
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3] |-> (o_m_tdata[2:0] == sle_pkg::ST_DONE))
        else $error("found with error status");

    // A removed value only appears on a clean status
    a_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[35:4] != '0) |-> (o_m_tdata[2:0] == sle_pkg::ST_DONE))
        else $error("removed value with error status");

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tdata  (i_s_tdata),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire

### bench/sle_result_checker.sv
// Result checker for the sorted list engine: watches both stream channels,
// predicts each result from its own copy of the list and compares.
// Depends on sle_pkg for the command and status codes and the list depth.

module sle_result_checker (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // command [1:0], value [33:2], position [38:34]
    input  wire logic [sle_pkg::IN_W-1:0] i_s_tdata,
    input  wire logic                     i_s_tvalid,
    input  wire logic                     i_s_tready,
    // status [2:0], found [3], removed_value [35:4], count [40:36]
    input  wire logic [sle_pkg::OUT_W-1:0] i_m_tdata,
    input  wire logic                     i_m_tvalid,
    input  wire logic                     i_m_tready,
    input  wire logic                     i_run_done,
    output int                            o_pending,
    output int                            o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        t_status                 status;
        logic                    found;
        logic signed [VAL_W-1:0] removed;
        logic [CNT_W-1:0]        count;
    } t_list_result;

    // Shadow copy of the sorted list
    logic signed [VAL_W-1:0] shadow_list [DEPTH];
    int                      shadow_count;

    t_list_result expected_results [$];
    int           error_count;
    int           pending_size;
    int           commands_seen;
    int           results_seen;
    int           peak_count;
    int           status_tally [5];
    bit           summary_done;

    initial begin
        error_count   = 0;
        pending_size  = 0;
        commands_seen = 0;
        results_seen  = 0;
        peak_count    = 0;
        summary_done  = 1'b0;
        shadow_count  = 0;
        foreach (status_tally[k]) status_tally[k] = 0;
    end

    assign o_pending    = pending_size;
    assign o_fail_count = error_count + (i_run_done ? pending_size : 0);

    // Apply one command to the shadow list and return the result it gives
    function automatic t_list_result apply_list_command(logic [1:0] cmd,
                                                        logic signed [VAL_W-1:0] val,
                                                        logic [POS_W-1:0] pos);
        t_list_result res;
        int           at;
        res = '{status: ST_DONE, found: 1'b0, removed: '0, count: '0};
        if (cmd == CMD_INSERT) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                at = 0;
                while (at < shadow_count && shadow_list[at] <= val) at++;
                for (int i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
                shadow_list[at] = val;
                shadow_count++;
            end
        end else if (cmd == CMD_DELETE) begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else if (pos == 0 || int'(pos) > shadow_count) begin
                res.status = ST_BADPOS;
            end else begin
                res.removed = shadow_list[pos-1];
                for (int i = int'(pos) - 1; i + 1 < shadow_count; i++)
                    shadow_list[i] = shadow_list[i+1];
                shadow_count--;
            end
        end else if (cmd == CMD_SEARCH) begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_list[i] == val) res.found = 1'b1;
                if (!res.found) res.status = ST_NOKEY;
            end
        end
        // any other command code leaves the list alone
        res.count = CNT_W'(shadow_count);
        return res;
    endfunction

    // Check each result transfer first, then predict from each command transfer
    always @(posedge i_clk) begin : watch
        t_list_result            want;
        t_list_result            prediction;
        logic [2:0]              got_status;
        logic                    got_found;
        logic signed [VAL_W-1:0] got_removed;
        logic [CNT_W-1:0]        got_count;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
            pending_size = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_status  = i_m_tdata[2:0];
                got_found   = i_m_tdata[3];
                got_removed = i_m_tdata[35:4];
                got_count   = i_m_tdata[40:36];
                results_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("%0t: unexpected result status %0d found %0d removed %0d count %0d",
                                 $realtime, got_status, got_found, got_removed, got_count);
                end else begin
                    want = expected_results.pop_front();
                    if (got_status !== want.status || got_found !== want.found ||
                        got_removed !== want.removed || got_count !== want.count) begin
                        error_count++;
                        if (error_count <= MAX_SHOWN)
                            $display({"%0t: result %0d mismatch: expected status %0d found %0d ",
                                      "removed %0d count %0d, got status %0d found %0d ",
                                      "removed %0d count %0d"},
                                     $realtime, results_seen, want.status, want.found,
                                     want.removed, want.count, got_status, got_found,
                                     got_removed, got_count);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                prediction = apply_list_command(i_s_tdata[1:0], i_s_tdata[33:2],
                                                i_s_tdata[38:34]);
                expected_results.push_back(prediction);
                status_tally[prediction.status]++;
                commands_seen++;
                if (shadow_count > peak_count) peak_count = shadow_count;
            end
            pending_size = expected_results.size();
            if (i_run_done && !summary_done) begin
                summary_done = 1'b1;
                $display({"Covered %0d commands, %0d results: %0d done, %0d on empty list, ",
                          "%0d bad position, %0d on full list, %0d key misses; peak fill %0d"},
                         commands_seen, results_seen, status_tally[ST_DONE],
                         status_tally[ST_EMPTY], status_tally[ST_BADPOS],
                         status_tally[ST_FULL], status_tally[ST_NOKEY], peak_count);
            end
        end
    end

endmodule

### bench/sorted_list_engine_core_tb.sv
// Top of the sorted list engine bench: clock, reset, command stimulus and
// result back-pressure. Depends on sle_pkg, sorted_list_engine_core and sle_result_checker.

module sorted_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    // Command code outside the three the block knows
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_LEN    = 100;
    localparam int HOLD_CYCLES  = 80;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              run_done = 1'b0;
    int                pending;
    int                fail_count;

    bit sender_idles      = 1'b0;
    bit receiver_idles    = 1'b0;
    int hold_off_requests = 0;
    int hold_offs_served  = 0;

    // Recently inserted values, so that searches and duplicates hit
    logic signed [VAL_W-1:0] recent_values [$];

    sorted_list_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready)
    );

    sle_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_run_done   (run_done),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // Offer one command, holding it until the block takes the transfer
    task automatic send_command(input logic [1:0] cmd, input logic signed [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        while (sender_idles && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, val, cmd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (cmd == CMD_INSERT) begin
            recent_values.push_back(val);
            if (recent_values.size() > 32) void'(recent_values.pop_front());
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $signed($urandom_range(0, 8)) - 4;
        if (r < 4 && recent_values.size() > 0)
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly valid positions, shallow ones when draining, now and then anything
    function automatic logic [POS_W-1:0] pick_position(bit shallow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return POS_W'($urandom_range(0, 31));
        if (shallow && r < 70) return POS_W'($urandom_range(1, 3));
        return POS_W'($urandom_range(1, DEPTH));
    endfunction

    // Pick a command weighted by phase: fill, mixed or drain
    function automatic logic [1:0] pick_command(int phase);
        int r;
        int ins_w;
        int del_w;
        r = $urandom_range(0, 99);
        ins_w = (phase == 0) ? 60 : (phase == 1) ? 35 : 15;
        del_w = (phase == 0) ? 15 : (phase == 1) ? 30 : 60;
        if (r < ins_w) return CMD_INSERT;
        if (r < ins_w + del_w) return CMD_DELETE;
        if (r < 95) return CMD_SEARCH;
        return CMD_UNUSED;
    endfunction

    // Drive result back-pressure; serve long hold-offs when asked
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_offs_served != hold_off_requests) begin
                hold_offs_served++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(receiver_idles && $urandom_range(0, 99) < 9);
            end
        end
    end

    initial begin : stimulus
        logic signed [VAL_W-1:0] seed_values [DEPTH];
        logic [1:0]              cmd;
        int                      phase;
        int                      drain_cycles;
        seed_values = '{VAL_MIN, VAL_MAX, 0, -1, 0, 7, -7, 1,
                        VAL_MAX, 100, -100, 42, 42, 3, -3, VAL_MIN};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty list cases and the unused command
        send_command(CMD_DELETE, 0, 1);
        send_command(CMD_SEARCH, 0, 0);
        send_command(CMD_UNUSED, -1, 31);
        // Fill to the brim with extremes and duplicates, then one too many
        foreach (seed_values[k]) send_command(CMD_INSERT, seed_values[k], 0);
        send_command(CMD_INSERT, 5, 0);
        send_command(CMD_SEARCH, VAL_MAX, 0);
        send_command(CMD_SEARCH, 12345, 0);
        send_command(CMD_DELETE, 0, 0);
        send_command(CMD_DELETE, 0, 17);
        send_command(CMD_DELETE, 0, 1);
        send_command(CMD_DELETE, 0, 15);
        send_command(CMD_UNUSED, -1, 31);

        // Random phases; no idling for the first few hundred commands
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase          = (n / PHASE_LEN) % 3;
            sender_idles   = (n >= 400);
            receiver_idles = (n >= 400);
            if (n == 700 || n == 1500) hold_off_requests++;
            cmd = pick_command(phase);
            send_command(cmd, (cmd == CMD_SEARCH && recent_values.size() > 0 &&
                               $urandom_range(0, 1)) ?
                              recent_values[$urandom_range(0, recent_values.size() - 1)] :
                              pick_value(),
                         pick_position(phase == 2));
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for the output register
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < 20000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (4) @(negedge i_clk);
        run_done <= 1'b1;
        @(negedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
